// ===== rtl/core/tro_pkg.sv =====
package tro_pkg;

    // Datapath widths shared by the rotation unit, the gain unit and the sequencer
    localparam int CORDIC_W = 44;   // x/y vector, 16 guard bits below Q.8
    localparam int Z_W      = 33;   // angle in turns, 2^32 per full turn
    localparam int GUARD    = 16;
    localparam int G_W      = CORDIC_W - GUARD + 1;  // signed gain-corrected value

    // Gain correction K = 2608131497 / 2^32, split into two 16-bit halves
    localparam logic [15:0] GAIN_HI    = 16'd39796;
    localparam logic [15:0] GAIN_LO    = 16'd60841;
    localparam int          GAIN_SHIFT = 32;

    localparam logic signed [Z_W-1:0] QUARTER_TURN = Z_W'(1073741824);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_VEC,
        S_VG_ISSUE,
        S_VG_WAIT,
        S_VG_CAP,
        S_ERR,
        S_DIV1,
        S_DIV2,
        S_RLOAD,
        S_ROT,
        S_RG_X,
        S_RG_Y,
        S_RG_F,
        S_RG_L,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;     // take the initial vector and angle, restart the count
        logic step;     // run one micro-rotation
        logic rotate;   // 1: drive the angle to zero, 0: drive y to zero
    } t_cordic_ctl;

    // Elementary angles atan(2^-i) in turns, 2^32 per full turn
    function automatic logic [29:0] atan_turn(input logic [4:0] idx);
        logic [29:0] a;
        case (idx)
            5'd0:  a = 30'd536870912;
            5'd1:  a = 30'd316933406;
            5'd2:  a = 30'd167458907;
            5'd3:  a = 30'd85004756;
            5'd4:  a = 30'd42667331;
            5'd5:  a = 30'd21354465;
            5'd6:  a = 30'd10679838;
            5'd7:  a = 30'd5340245;
            5'd8:  a = 30'd2670163;
            5'd9:  a = 30'd1335087;
            5'd10: a = 30'd667544;
            5'd11: a = 30'd333772;
            5'd12: a = 30'd166886;
            5'd13: a = 30'd83443;
            5'd14: a = 30'd41722;
            5'd15: a = 30'd20861;
            5'd16: a = 30'd10430;
            5'd17: a = 30'd5215;
            5'd18: a = 30'd2608;
            5'd19: a = 30'd1304;
            5'd20: a = 30'd652;
            5'd21: a = 30'd326;
            5'd22: a = 30'd163;
            5'd23: a = 30'd81;
            5'd24: a = 30'd41;
            5'd25: a = 30'd20;
            5'd26: a = 30'd10;
            5'd27: a = 30'd5;
            5'd28: a = 30'd3;
            5'd29: a = 30'd1;
            5'd30: a = 30'd1;
            default: a = 30'd0;
        endcase
        return a;
    endfunction

endpackage

// ===== rtl/core/target_relative_offset.sv =====
// Target position relative to a moving body.
// Input channel (i_valid/o_ready): one beat carries the target point, the
// current point (Q.8) and the current heading (degrees, Q.7).
// Output channel (o_valid/i_ready): one beat per input beat with distance,
// bearing, wrapped heading error and the lateral and forward offsets.
// One shared CORDIC unit does one micro-rotation per cycle: first in
// vectoring mode for distance and bearing, then in rotation mode for the
// body-frame offsets. A two-stage gain multiplier scales its results.
// A new item is accepted only after the last one has left the sequencer
// for the output register. Coincident points skip both CORDIC passes.
// The rate is set by the two passes through the single unit.
// o_ready is high only while the block is idle. A finished result sits in
// the output register; a stalled receiver holds it there, the next item is
// still taken and computed, and waits until the output register frees up.
// Reset clears the sequencer, the output valid and the held bearing (0).
module target_relative_offset #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [23:0] i_target_x,
    input  logic signed [23:0] i_target_y,
    input  logic signed [23:0] i_current_x,
    input  logic signed [23:0] i_current_y,
    input  logic signed [17:0] i_heading,
    output logic               o_valid,
    input  logic               i_ready,
    output logic        [24:0] o_distance,
    output logic signed [15:0] o_bearing,
    output logic signed [15:0] o_heading_error,
    output logic signed [25:0] o_lateral_offset,
    output logic signed [25:0] o_forward_offset
);

    localparam int N_STEPS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    localparam int W       = tro_pkg::CORDIC_W;
    localparam int ZW      = tro_pkg::Z_W;
    localparam int GW      = tro_pkg::G_W;
    localparam int PW      = ZW + 17;

    localparam logic signed [15:0] HALF_Q7 = 16'sd23040;
    localparam logic signed [18:0] HALF_19 = 19'sd23040;
    localparam logic signed [18:0] FULL_19 = 19'sd46080;
    localparam logic signed [17:0] HALF_18 = 18'sd23040;

    tro_pkg::t_state      r_state, n_state;
    tro_pkg::t_cordic_ctl cctl;

    logic signed [24:0]   r_dx, r_dy;
    logic signed [17:0]   r_hd;
    logic signed [15:0]   r_held, r_bearing, r_err;
    logic        [24:0]   r_dist;
    logic signed [PW-1:0] r_zprod;
    logic        [20:0]   r_u;
    logic        [42:0]   r_p1;
    logic signed [32:0]   r_p2;
    logic signed [ZW-1:0] r_t;
    logic signed [25:0]   r_fwd, r_lat;
    logic                 r_o_valid;
    logic        [24:0]   r_o_dist;
    logic signed [15:0]   r_o_bearing, r_o_err;
    logic signed [25:0]   r_o_lat, r_o_fwd;

    logic signed [W-1:0]  c_x, c_y, c_x0, c_y0;
    logic signed [ZW-1:0] c_z, c_z0;
    logic                 c_done;
    logic                 gain_start, gain_sel_y, gain_valid;
    logic signed [GW-1:0] gain_r;
    logic                 out_load, coinc;

    logic signed [W-1:0]  vx, vy, vec_x0, vec_y0, rd, rot_x0, rot_y0;
    logic signed [ZW-1:0] vec_z0, rot_z0;
    logic signed [PW-1:0] bsum;
    logic signed [17:0]   b18;
    logic signed [15:0]   b_clamped;
    logic signed [22:0]   u_s;
    logic        [15:0]   q16;
    logic        [21:0]   q45, rem;
    logic        [16:0]   qc;

    // Wrap an angle difference into [-180, 180] degrees, at most five passes
    function automatic logic signed [15:0] wrap_err(input logic signed [18:0] e);
        logic signed [18:0] v;
        v = e;
        for (int k = 0; k < 5; k++) begin
            if (v > HALF_19) begin
                v = v - FULL_19;
            end else if (v < -HALF_19) begin
                v = v + FULL_19;
            end
        end
        return v[15:0];
    endfunction

    // Saturate a gain-corrected value to the 26-bit offset range
    function automatic logic signed [25:0] clamp26(input logic signed [GW-1:0] g);
        logic signed [25:0] r;
        if (g > $signed(GW'(33554431))) begin
            r = 26'sh1FFFFFF;
        end else if (g < -$signed(GW'(33554432))) begin
            r = 26'sh2000000;
        end else begin
            r = g[25:0];
        end
        return r;
    endfunction

    tro_cordic #(
        .N_STEPS (N_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (cctl),
        .i_x0    (c_x0),
        .i_y0    (c_y0),
        .i_z0    (c_z0),
        .o_x     (c_x),
        .o_y     (c_y),
        .o_z     (c_z),
        .o_done  (c_done)
    );

    tro_gain u_gain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (gain_start),
        .i_v     (gain_sel_y ? c_y : c_x),
        .o_valid (gain_valid),
        .o_r     (gain_r)
    );

    assign coinc = (r_dx == 25'sd0) && (r_dy == 25'sd0);

    // Vectoring start: move a left-half vector into the right half by a quarter turn
    always_comb begin
        vx = W'(r_dx) <<< tro_pkg::GUARD;
        vy = W'(r_dy) <<< tro_pkg::GUARD;
        vec_x0 = vx;
        vec_y0 = vy;
        vec_z0 = '0;
        if (vx < 0) begin
            if (vy >= 0) begin
                vec_x0 = vy;
                vec_y0 = -vx;
                vec_z0 = tro_pkg::QUARTER_TURN;
            end else begin
                vec_x0 = -vy;
                vec_y0 = vx;
                vec_z0 = -tro_pkg::QUARTER_TURN;
            end
        end
    end

    // Rotation start: turn (distance, 0) by a quarter when the error is large
    always_comb begin
        rd = $signed(W'({r_dist, 16'b0}));
        rot_x0 = rd;
        rot_y0 = '0;
        rot_z0 = r_t;
        if (r_t > tro_pkg::QUARTER_TURN) begin
            rot_x0 = '0;
            rot_y0 = rd;
            rot_z0 = r_t - tro_pkg::QUARTER_TURN;
        end else if (r_t < -tro_pkg::QUARTER_TURN) begin
            rot_x0 = '0;
            rot_y0 = -rd;
            rot_z0 = r_t + tro_pkg::QUARTER_TURN;
        end
    end

    assign c_x0 = (r_state == tro_pkg::S_RLOAD) ? rot_x0 : vec_x0;
    assign c_y0 = (r_state == tro_pkg::S_RLOAD) ? rot_y0 : vec_y0;
    assign c_z0 = (r_state == tro_pkg::S_RLOAD) ? rot_z0 : vec_z0;

    // Bearing: angle in turns to degrees Q.7 with rounding, then saturate
    assign bsum = r_zprod + PW'(64'sh80000000);
    assign b18  = bsum[PW-1:32];
    always_comb begin
        if (b18 > HALF_18) begin
            b_clamped = HALF_Q7;
        end else if (b18 < -HALF_18) begin
            b_clamped = -HALF_Q7;
        end else begin
            b_clamped = b18[15:0];
        end
    end

    // Error to turns: floor((e*2^22 + 22) / 45) as e*93206 + floor((34e + 22) / 45)
    assign u_s = 23'(r_err) * 23'sd34 + 23'sd783427;
    assign q16 = r_p1[42:27];
    assign q45 = 22'(q16) * 22'd45;
    assign rem = {1'b0, r_u} - q45;
    assign qc  = (rem >= 22'd45) ? 17'(q16) + 17'd1 : 17'(q16);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tro_pkg::S_IDLE:     if (i_valid) n_state = tro_pkg::S_LOAD;
            tro_pkg::S_LOAD:     n_state = coinc ? tro_pkg::S_ERR : tro_pkg::S_VEC;
            tro_pkg::S_VEC:      if (c_done) n_state = tro_pkg::S_VG_ISSUE;
            tro_pkg::S_VG_ISSUE: n_state = tro_pkg::S_VG_WAIT;
            tro_pkg::S_VG_WAIT:  n_state = tro_pkg::S_VG_CAP;
            tro_pkg::S_VG_CAP:   n_state = tro_pkg::S_ERR;
            tro_pkg::S_ERR:      n_state = (r_dist == '0) ? tro_pkg::S_OUT : tro_pkg::S_DIV1;
            tro_pkg::S_DIV1:     n_state = tro_pkg::S_DIV2;
            tro_pkg::S_DIV2:     n_state = tro_pkg::S_RLOAD;
            tro_pkg::S_RLOAD:    n_state = tro_pkg::S_ROT;
            tro_pkg::S_ROT:      if (c_done) n_state = tro_pkg::S_RG_X;
            tro_pkg::S_RG_X:     n_state = tro_pkg::S_RG_Y;
            tro_pkg::S_RG_Y:     n_state = tro_pkg::S_RG_F;
            tro_pkg::S_RG_F:     n_state = tro_pkg::S_RG_L;
            tro_pkg::S_RG_L:     n_state = tro_pkg::S_OUT;
            tro_pkg::S_OUT:      if (!r_o_valid || i_ready) n_state = tro_pkg::S_IDLE;
            default:             n_state = tro_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        cctl       = '0;
        gain_start = 1'b0;
        gain_sel_y = 1'b0;
        o_ready    = 1'b0;
        out_load   = 1'b0;
        case (r_state)
            tro_pkg::S_IDLE:     o_ready = 1'b1;
            tro_pkg::S_LOAD:     cctl.load = !coinc;
            tro_pkg::S_VEC:      cctl.step = 1'b1;
            tro_pkg::S_VG_ISSUE: gain_start = 1'b1;
            tro_pkg::S_RLOAD:    cctl.load = 1'b1;
            tro_pkg::S_ROT: begin
                cctl.step   = 1'b1;
                cctl.rotate = 1'b1;
            end
            tro_pkg::S_RG_X:     gain_start = 1'b1;
            tro_pkg::S_RG_Y: begin
                gain_start = 1'b1;
                gain_sel_y = 1'b1;
            end
            tro_pkg::S_OUT:      out_load = !r_o_valid || i_ready;
            default: begin
                cctl = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tro_pkg::S_IDLE;
            r_o_valid <= 1'b0;
            r_held    <= '0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
            if (r_state == tro_pkg::S_VG_CAP) begin
                r_held <= b_clamped;
            end
        end
    end

    // Working registers, one group per sequencer step
    always_ff @(posedge i_clk) begin
        case (r_state)
            tro_pkg::S_IDLE: begin
                r_dx <= 25'(i_target_x) - 25'(i_current_x);
                r_dy <= 25'(i_target_y) - 25'(i_current_y);
                r_hd <= i_heading;
            end
            tro_pkg::S_LOAD: begin
                if (coinc) begin
                    r_bearing <= r_held;
                    r_dist    <= '0;
                end
            end
            tro_pkg::S_VG_ISSUE: begin
                r_zprod <= PW'(c_z) * PW'(46080);
            end
            tro_pkg::S_VG_CAP: begin
                r_bearing <= b_clamped;
                if (gain_r < 0) begin
                    r_dist <= '0;
                end else if (gain_r > $signed(GW'(33554431))) begin
                    r_dist <= 25'h1FFFFFF;
                end else begin
                    r_dist <= gain_r[24:0];
                end
            end
            tro_pkg::S_ERR: begin
                r_err <= wrap_err(19'(r_bearing) - 19'(r_hd));
                r_fwd <= '0;
                r_lat <= '0;
            end
            tro_pkg::S_DIV1: begin
                r_u  <= u_s[20:0];
                r_p1 <= 43'(u_s[20:0]) * 43'd2982616;
                r_p2 <= 33'(r_err) * 33'sd93206;
            end
            tro_pkg::S_DIV2: begin
                r_t <= r_p2 + $signed(33'(qc)) - 33'sd17409;
            end
            tro_pkg::S_RG_F: begin
                r_fwd <= clamp26(gain_r);
            end
            tro_pkg::S_RG_L: begin
                r_lat <= clamp26(-gain_r);
            end
            default: begin
                r_t <= r_t;
            end
        endcase
    end

    // Output register: load when the slot is free or being drained
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_dist    <= r_dist;
            r_o_bearing <= r_bearing;
            r_o_err     <= r_err;
            r_o_lat     <= r_lat;
            r_o_fwd     <= r_fwd;
        end
    end

    assign o_valid          = r_o_valid;
    assign o_distance       = r_o_dist;
    assign o_bearing        = r_o_bearing;
    assign o_heading_error  = r_o_err;
    assign o_lateral_offset = r_o_lat;
    assign o_forward_offset = r_o_fwd;

    // Gain results land exactly in the capture steps
    a_gain_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tro_pkg::S_VG_CAP || r_state == tro_pkg::S_RG_F ||
         r_state == tro_pkg::S_RG_L) |-> gain_valid)
        else $error("gain result not ready at capture");

    // The vectoring pass is finished before its result is scaled
    a_vec_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tro_pkg::S_VG_ISSUE) |-> c_done)
        else $error("vectoring pass not finished");

    // Held bearing changes only when a new bearing is captured
    a_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != tro_pkg::S_VG_CAP) |=> $stable(r_held))
        else $error("held bearing changed outside capture");

    // Wrapped error is inside the half-turn range before conversion
    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tro_pkg::S_DIV1) |-> (r_err <= HALF_Q7 && r_err >= -HALF_Q7))
        else $error("heading error out of range");

    // Zero distance gives zero offsets
    a_coinc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tro_pkg::S_OUT && r_dist == '0) |-> (r_lat == '0 && r_fwd == '0))
        else $error("nonzero offset at zero distance");

endmodule

// ===== rtl/core/tro_cordic.sv =====
module tro_cordic #(
    parameter int N_STEPS = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tro_pkg::t_cordic_ctl                i_ctl,
    input  logic signed [tro_pkg::CORDIC_W-1:0] i_x0,
    input  logic signed [tro_pkg::CORDIC_W-1:0] i_y0,
    input  logic signed [tro_pkg::Z_W-1:0]      i_z0,
    output logic signed [tro_pkg::CORDIC_W-1:0] o_x,
    output logic signed [tro_pkg::CORDIC_W-1:0] o_y,
    output logic signed [tro_pkg::Z_W-1:0]      o_z,
    output logic                                o_done
);

    localparam int W  = tro_pkg::CORDIC_W;
    localparam int ZW = tro_pkg::Z_W;
    localparam int CW = $clog2(N_STEPS + 1);
    localparam int IW = $clog2(N_STEPS);

    logic signed [W-1:0]  r_x, r_y, n_x, n_y;
    logic signed [ZW-1:0] r_z, n_z;
    logic [CW-1:0]        r_cnt;
    logic [IW-1:0]        idx;
    logic signed [W-1:0]  xs, ys;
    logic signed [ZW-1:0] az;
    logic                 ccw;

    // One micro-rotation: shift both legs by the step index, add or subtract
    assign idx = r_cnt[IW-1:0];
    assign xs  = r_x >>> idx;
    assign ys  = r_y >>> idx;
    assign az  = $signed(ZW'(tro_pkg::atan_turn(5'(idx))));

    // Turn counterclockwise when y is below the axis, or when angle is left to go
    assign ccw = i_ctl.rotate ? !r_z[ZW-1] : r_y[W-1];

    always_comb begin
        n_x = ccw ? r_x - ys : r_x + ys;
        n_y = ccw ? r_y + xs : r_y - xs;
        n_z = ccw ? r_z - az : r_z + az;
    end

    assign o_done = (r_cnt == CW'(N_STEPS));
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;

    // Step counter: park at the end count after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= CW'(N_STEPS);
        end else if (i_ctl.load) begin
            r_cnt <= '0;
        end else if (i_ctl.step && !o_done) begin
            r_cnt <= r_cnt + CW'(1);
        end
    end

    // Vector and angle registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_x <= i_x0;
            r_y <= i_y0;
            r_z <= i_z0;
        end else if (i_ctl.step && !o_done) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

endmodule

// ===== rtl/core/tro_gain.sv =====
module tro_gain (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [tro_pkg::CORDIC_W-1:0] i_v,
    output logic                                o_valid,
    output logic signed [tro_pkg::G_W-1:0]      o_r
);

    localparam int W  = tro_pkg::CORDIC_W;
    localparam int GW = tro_pkg::G_W;
    localparam int SH = tro_pkg::GAIN_SHIFT;
    localparam logic [W+16:0] ROUND = (W + 17)'(1) << (31 + tro_pkg::GUARD);

    logic [W-1:0]    mag;
    logic [W+15:0]   r_phi;
    logic [W+16:0]   r_q;
    logic            r_neg;
    logic            r_v1, r_v2;
    logic [W+16:0]   sum;
    logic [W-17:0]   mag_r;

    // Stage 1: magnitude times both halves of the gain, rounding bias on the low half
    assign mag = i_v[W-1] ? W'(-i_v) : W'(i_v);

    always_ff @(posedge i_clk) begin
        r_phi <= (W + 16)'(mag) * (W + 16)'(tro_pkg::GAIN_HI);
        r_q   <= (W + 17)'(mag) * (W + 17)'(tro_pkg::GAIN_LO) + ROUND;
        r_neg <= i_v[W-1];
    end

    // Stage 2: combine the halves, drop the fraction, restore the sign
    assign sum   = (W + 17)'(r_phi) + (r_q >> 16);
    assign mag_r = sum[W+15:SH];

    always_ff @(posedge i_clk) begin
        o_r <= r_neg ? -$signed(GW'(mag_r)) : $signed(GW'(mag_r));
    end

    // Track beats through the two stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
        end
    end

    assign o_valid = r_v2;

endmodule
